@@ rtl/dma_port_region_classifier_macros.svh @@
// assertion macros for the region classifier checker
`ifndef DMA_PORT_REGION_CLASSIFIER_MACROS_SVH
`define DMA_PORT_REGION_CLASSIFIER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DPRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dprc check failed");

// consequent must hold in the cycle after the antecedent
`define DPRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dprc check failed");

`endif

@@ rtl/dprc_pkg.sv @@
package dprc_pkg;

  localparam int LEN_W       = 33;
  localparam int OUT_ADDR_W  = 32;
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_COLLIDE = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT   = 1'b0,
    OP_CLASSIFY = 1'b1
  } opcode_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic eval;
    logic mark_full;
    logic wr_en;
    logic wr_shift;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_insert;
    logic le_new;
    logic collide;
  } sts_t;

endpackage

@@ rtl/dprc_ctrl.sv @@
module dprc_ctrl
  import dprc_pkg::*;
#(
  parameter int MAX_REGIONS = 16,
  parameter int CW          = $clog2(MAX_REGIONS + 1),
  parameter int IW          = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  opcode_t       in_opcode,
  output logic          out_valid,
  input  logic          out_ready,
  output cmd_t          cmd,
  output logic [IW-1:0] rd_addr,
  output logic [IW-1:0] wr_addr,
  input  sts_t          sts
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_READ     = 8'b0000_0010,
    S_EVAL     = 8'b0000_0100,
    S_DECIDE   = 8'b0000_1000,
    S_SHIFT_RD = 8'b0001_0000,
    S_SHIFT_WR = 8'b0010_0000,
    S_PLACE    = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] idx_inc, idx_dec;

  assign idx_inc = idx + CW'(1);
  assign idx_dec = idx - CW'(1);

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    pos_next   = pos;
    cmd        = '0;
    rd_addr    = idx[IW-1:0];
    wr_addr    = idx[IW-1:0];
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          idx_next    = '0;
          pos_next    = '0;
          if (count != '0) begin
            state_next = S_READ;
          end else if (in_opcode == OP_INSERT) begin
            state_next = S_DECIDE;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.is_insert && sts.le_new) begin
          pos_next = pos + CW'(1);
        end
        idx_next = idx_inc;
        if (idx_inc == count) begin
          state_next = sts.is_insert ? S_DECIDE : S_FINISH;
        end else begin
          state_next = S_READ;
        end
      end
      S_DECIDE: begin
        if (sts.collide) begin
          state_next = S_FINISH;
        end else if (count == CW'(MAX_REGIONS)) begin
          cmd.mark_full = 1'b1;
          state_next    = S_FINISH;
        end else begin
          idx_next   = count;
          state_next = (count == pos) ? S_PLACE : S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.rd_en  = 1'b1;
        rd_addr    = idx_dec[IW-1:0];
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_shift = 1'b1;
        idx_next     = idx_dec;
        state_next   = (idx_dec == pos) ? S_PLACE : S_SHIFT_RD;
      end
      S_PLACE: begin
        cmd.wr_en  = 1'b1;
        wr_addr    = pos[IW-1:0];
        count_next = count + CW'(1);
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      pos   <= pos_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/dprc_datapath.sv @@
module dprc_datapath
  import dprc_pkg::*;
#(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_W      = 32,
  parameter int IW          = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
  input  logic                  clk,
  input  cmd_t                  cmd,
  input  logic [IW-1:0]         rd_addr,
  input  logic [IW-1:0]         wr_addr,
  output sts_t                  sts,
  input  opcode_t               opcode,
  input  logic [ADDR_W-1:0]     region_start,
  input  logic [LEN_W-1:0]      region_size,
  input  logic [ADDR_W-1:0]     region_local_base,
  input  logic [ADDR_W-1:0]     src_address,
  input  logic [ADDR_W-1:0]     dst_address,
  input  logic                  src_linear,
  input  logic                  dst_linear,
  output status_t               status,
  output logic                  src_is_memory,
  output logic                  dst_is_memory,
  output logic                  fast_path,
  output logic [OUT_ADDR_W-1:0] src_local_address,
  output logic [OUT_ADDR_W-1:0] dst_local_address
);

  localparam int ENTRY_W = 2 * ADDR_W + LEN_W;

  // region table: {local base, length, start}
  logic [ENTRY_W-1:0] mem [MAX_REGIONS];
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] wdata;

  opcode_t            op;
  logic [ADDR_W-1:0]  n_start, n_base, src_a, dst_a;
  logic [LEN_W-1:0]   n_len;
  logic               src_lin, dst_lin;
  logic               collide, full;

  logic               src_found, dst_found;
  logic [ADDR_W-1:0]  src_off, dst_off, src_base, dst_base;
  logic [LEN_W-1:0]   src_len, dst_len;

  logic [ADDR_W-1:0]  e_start, e_base;
  logic [LEN_W-1:0]   e_len;
  logic [ADDR_W:0]    d_new, d_old, d_src, d_dst;
  logic               overlap;
  logic               src_mem, dst_mem;

  assign {e_base, e_len, e_start} = rdata;
  assign wdata = cmd.wr_shift ? rdata : {n_base, n_len, n_start};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // overlap test in both directions, no wrap
  assign d_new   = {1'b0, n_start} - {1'b0, e_start};
  assign d_old   = {1'b0, e_start} - {1'b0, n_start};
  assign overlap = !d_new[ADDR_W] ? (LEN_W'(d_new[ADDR_W-1:0]) < e_len)
                                  : (LEN_W'(d_old[ADDR_W-1:0]) < n_len);
  assign d_src   = {1'b0, src_a} - {1'b0, e_start};
  assign d_dst   = {1'b0, dst_a} - {1'b0, e_start};

  assign sts.is_insert = (op == OP_INSERT);
  assign sts.le_new    = !d_new[ADDR_W];
  assign sts.collide   = collide;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op        <= opcode;
      n_start   <= region_start;
      n_len     <= region_size;
      n_base    <= region_local_base;
      src_a     <= src_address;
      dst_a     <= dst_address;
      src_lin   <= src_linear;
      dst_lin   <= dst_linear;
      collide   <= 1'b0;
      full      <= 1'b0;
      src_found <= 1'b0;
      dst_found <= 1'b0;
    end else begin
      if (cmd.mark_full) begin
        full <= 1'b1;
      end
      if (cmd.eval) begin
        if (op == OP_INSERT && overlap) begin
          collide <= 1'b1;
        end
        // table is sorted, so the last hit wins
        if (!d_src[ADDR_W]) begin
          src_found <= 1'b1;
          src_off   <= d_src[ADDR_W-1:0];
          src_len   <= e_len;
          src_base  <= e_base;
        end
        if (!d_dst[ADDR_W]) begin
          dst_found <= 1'b1;
          dst_off   <= d_dst[ADDR_W-1:0];
          dst_len   <= e_len;
          dst_base  <= e_base;
        end
      end
    end
  end

  assign src_mem = src_found && src_lin && (LEN_W'(src_off) < src_len);
  assign dst_mem = dst_found && dst_lin && (LEN_W'(dst_off) < dst_len);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (op == OP_INSERT) begin
        status            <= collide ? ST_COLLIDE : (full ? ST_FULL : ST_OK);
        src_is_memory     <= 1'b0;
        dst_is_memory     <= 1'b0;
        fast_path         <= 1'b0;
        src_local_address <= '0;
        dst_local_address <= '0;
      end else begin
        status            <= ST_OK;
        src_is_memory     <= src_mem;
        dst_is_memory     <= dst_mem;
        fast_path         <= src_mem && dst_mem;
        src_local_address <= src_mem ? OUT_ADDR_W'(ADDR_W'(src_base + src_off)) : '0;
        dst_local_address <= dst_mem ? OUT_ADDR_W'(ADDR_W'(dst_base + dst_off)) : '0;
      end
    end
  end

endmodule

@@ rtl/dma_port_region_classifier.sv @@
// Region classifier for a DMA port pair. Holds a table of up to MAX_REGIONS memory
// regions kept in start-address order; an insert transfer adds one region (status
// ok, collides or full; a collision wins over full and the table is left as it was),
// and a classify transfer looks up source and destination addresses and returns
// whether each lies in a region with linear access, its local address, and a
// fast-path flag when both do. One item is worked at a time. Each item scans every
// stored region, reading and then evaluating one entry at a time; a stored insert
// then moves each region above its place up one slot and writes the new one. Every
// step reads or writes one entry of the region table. A finished result waits in
// the output register while the next item is taken. Addresses are handled at
// ADDR_BITS bits (capped at 32): wider address inputs are cut to that width and
// local addresses wrap there. Table contents are undefined after reset; only the
// entry count is cleared, so no clearing pass is needed.
module dma_port_region_classifier
  import dprc_pkg::*;
#(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // input transfer
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // region_start[31:0], region_size[64:32], region_local_base[96:65],
  // src_address[128:97], dst_address[160:129], src_linear[161], dst_linear[162]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  logic                   s_axis_tuser,
  // result transfer
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status[1:0], src_is_memory[2], dst_is_memory[3], fast_path[4],
  // src_local_address[36:5], dst_local_address[68:37]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // working address width
  localparam int EW = (ADDR_BITS < OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  // unpacking of the input transfer
  logic [OUT_ADDR_W-1:0] in_region_start;
  logic [LEN_W-1:0]      in_region_size;
  logic [OUT_ADDR_W-1:0] in_region_local_base;
  logic [OUT_ADDR_W-1:0] in_src_address;
  logic [OUT_ADDR_W-1:0] in_dst_address;
  logic                  in_src_linear;
  logic                  in_dst_linear;
  opcode_t               in_opcode;

  assign in_region_start      = s_axis_tdata[31:0];
  assign in_region_size       = s_axis_tdata[64:32];
  assign in_region_local_base = s_axis_tdata[96:65];
  assign in_src_address       = s_axis_tdata[128:97];
  assign in_dst_address       = s_axis_tdata[160:129];
  assign in_src_linear        = s_axis_tdata[161];
  assign in_dst_linear        = s_axis_tdata[162];
  assign in_opcode            = opcode_t'(s_axis_tuser);

  // controller / datapath link
  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;

  // result fields
  status_t               status;
  logic                  src_is_memory;
  logic                  dst_is_memory;
  logic                  fast_path;
  logic [OUT_ADDR_W-1:0] src_local_address;
  logic [OUT_ADDR_W-1:0] dst_local_address;

  // sequencer: table scan, insert shift and result hand-off
  dprc_ctrl #(
    .MAX_REGIONS (MAX_REGIONS),
    .CW          (CW),
    .IW          (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_opcode (in_opcode),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .sts       (sts)
  );

  // region table, compare logic and result register
  dprc_datapath #(
    .MAX_REGIONS (MAX_REGIONS),
    .ADDR_W      (EW),
    .IW          (IW)
  ) u_datapath (
    .clk               (clk),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .wr_addr           (wr_addr),
    .sts               (sts),
    .opcode            (in_opcode),
    .region_start      (in_region_start[EW-1:0]),
    .region_size       (in_region_size),
    .region_local_base (in_region_local_base[EW-1:0]),
    .src_address       (in_src_address[EW-1:0]),
    .dst_address       (in_dst_address[EW-1:0]),
    .src_linear        (in_src_linear),
    .dst_linear        (in_dst_linear),
    .status            (status),
    .src_is_memory     (src_is_memory),
    .dst_is_memory     (dst_is_memory),
    .fast_path         (fast_path),
    .src_local_address (src_local_address),
    .dst_local_address (dst_local_address)
  );

  // packing of the result transfer, pad bits at the top
  assign m_axis_tdata = {3'b000, dst_local_address, src_local_address,
                         fast_path, dst_is_memory, src_is_memory, status};

endmodule

@@ rtl/dprc_checker.sv @@
`include "dma_port_region_classifier_macros.svh"

module dprc_checker
  import dprc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic       out_wait;
  logic [1:0] out_status;
  // src_is_memory, dst_is_memory, fast_path
  logic [2:0] out_flags;

  assign out_wait   = m_axis_tvalid && !m_axis_tready;
  assign out_status = m_axis_tdata[1:0];
  assign out_flags  = m_axis_tdata[4:2];

  // a held result keeps its contents
  `DPRC_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid && $stable(m_axis_tdata))

  // one item in flight: no second transfer straight after acceptance
  `DPRC_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  `DPRC_ASSERT_NOW(a_status_code, m_axis_tvalid, out_status <= ST_FULL)

  `DPRC_ASSERT_NOW(a_fast_path, m_axis_tvalid, out_flags[2] == (out_flags[0] && out_flags[1]))

  // a refused insert never reports memory ports
  `DPRC_ASSERT_NOW(a_refused_clean, m_axis_tvalid && out_status != ST_OK, out_flags == 3'b000)

endmodule

bind dma_port_region_classifier dprc_checker u_dprc_checker (.*);

@@ tb/dma_port_region_classifier_scoreboard.sv @@
`timescale 1ns / 100ps

module dma_port_region_classifier_scoreboard
  import dprc_pkg::*;
#(
  parameter int MAX_REGIONS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int                     fail_count,
  output int                     outstanding
);

  // laid out as the low bits of m_axis_tdata
  typedef struct packed {
    logic [31:0] dst_local;
    logic [31:0] src_local;
    logic        fast;
    logic        dst_mem;
    logic        src_mem;
    status_t     status;
  } port_verdict_t;

  bit [31:0]   region_start [MAX_REGIONS];
  bit [LEN_W-1:0] region_len [MAX_REGIONS];
  bit [31:0]   region_base  [MAX_REGIONS];
  int unsigned region_count;

  port_verdict_t verdict_q[$];

  function automatic bit spans_overlap(bit [31:0] a, bit [LEN_W-1:0] la,
                                       bit [31:0] b, bit [LEN_W-1:0] lb);
    if (a <= b) begin
      return {1'b0, b - a} < la;
    end
    return {1'b0, a - b} < lb;
  endfunction

  function automatic status_t add_region(bit [31:0] start, bit [LEN_W-1:0] len,
                                         bit [31:0] base);
    int unsigned pos;
    for (int i = 0; i < region_count; i++) begin
      if (spans_overlap(region_start[i], region_len[i], start, len)) begin
        return ST_COLLIDE;
      end
    end
    if (region_count >= MAX_REGIONS) begin
      return ST_FULL;
    end
    // equal starts go after the ones already stored
    pos = 0;
    while (pos < region_count && region_start[pos] <= start) pos++;
    for (int i = region_count; i > pos; i--) begin
      region_start[i] = region_start[i-1];
      region_len[i]   = region_len[i-1];
      region_base[i]  = region_base[i-1];
    end
    region_start[pos] = start;
    region_len[pos]   = len;
    region_base[pos]  = base;
    region_count++;
    return ST_OK;
  endfunction

  function automatic bit lookup_port(bit [31:0] addr, bit linear,
                                     output logic [31:0] local_addr);
    int hit;
    hit = -1;
    local_addr = '0;
    for (int i = 0; i < region_count; i++) begin
      if (region_start[i] <= addr) hit = i;
    end
    if (hit < 0) return 1'b0;
    if ({1'b0, addr - region_start[hit]} >= region_len[hit]) return 1'b0;
    if (!linear) return 1'b0;
    local_addr = region_base[hit] + (addr - region_start[hit]);
    return 1'b1;
  endfunction

  function automatic port_verdict_t work_item(logic [IN_TDATA_W-1:0] word, logic op);
    port_verdict_t v;
    logic [31:0]   src_loc;
    logic [31:0]   dst_loc;
    bit            src_mem;
    bit            dst_mem;
    v = '0;
    if (opcode_t'(op) == OP_INSERT) begin
      v.status = add_region(word[31:0], word[64:32], word[96:65]);
    end else begin
      src_mem = lookup_port(word[128:97], word[161], src_loc);
      dst_mem = lookup_port(word[160:129], word[162], dst_loc);
      v.status    = ST_OK;
      v.src_mem   = src_mem;
      v.dst_mem   = dst_mem;
      v.fast      = src_mem && dst_mem;
      v.src_local = src_loc;
      v.dst_local = dst_loc;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    port_verdict_t want;
    port_verdict_t got;
    if (rst) begin
      region_count = 0;
      verdict_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        verdict_q.push_back(work_item(s_axis_tdata, s_axis_tuser));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = port_verdict_t'(m_axis_tdata[$bits(port_verdict_t)-1:0]);
        if (verdict_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: result transfer with nothing pending, data %h", $time, m_axis_tdata);
          end
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (got.status !== want.status || got.src_mem !== want.src_mem ||
              got.dst_mem !== want.dst_mem || got.fast !== want.fast ||
              got.src_local !== want.src_local || got.dst_local !== want.dst_local) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch status %0d/%0d src_mem %b/%b dst_mem %b/%b fast %b/%b",
                       $time, want.status, got.status, want.src_mem, got.src_mem,
                       want.dst_mem, got.dst_mem, want.fast, got.fast);
              $display("    src_local %h/%h dst_local %h/%h (want/got)",
                       want.src_local, got.src_local, want.dst_local, got.dst_local);
            end
            fail_count++;
          end
        end
      end
    end
    outstanding = verdict_q.size();
  end

endmodule

@@ tb/dma_port_region_classifier_tb.sv @@
`timescale 1ns / 100ps

module dma_port_region_classifier_tb;
  import dprc_pkg::*;

  // window kept clear of random regions so the table can always be filled at the end
  localparam longint unsigned WIN_LO = 64'h2000_0000;
  localparam longint unsigned WIN_HI = 64'h2001_0000;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 1500;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // region_start, region_size, region_local_base, src_address, dst_address,
  // src_linear, dst_linear (lowest bits first)
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // opcode
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // status, src_is_memory, dst_is_memory, fast_path, src_local_address,
  // dst_local_address (lowest bits first)
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int fail_count;
  int outstanding;
  bit rx_hold;

  // history of region transfers sent, used to aim classify addresses
  longint unsigned sent_start[$];
  longint unsigned sent_size[$];

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  dma_port_region_classifier u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dma_port_region_classifier_scoreboard u_scoreboard (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // present one item at the falling edge and hold it until the transfer happens
  task automatic offer_item(opcode_t op, logic [31:0] r_start, logic [LEN_W-1:0] r_size,
                            logic [31:0] r_base, logic [31:0] src, logic [31:0] dst,
                            logic src_lin, logic dst_lin);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[31:0]    = r_start;
    word[64:32]   = r_size;
    word[96:65]   = r_base;
    word[128:97]  = src;
    word[160:129] = dst;
    word[161]     = src_lin;
    word[162]     = dst_lin;
    @(negedge clk);
    s_axis_tdata  = word;
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // unused fields still carry random bits
  task automatic offer_insert(logic [31:0] r_start, logic [LEN_W-1:0] r_size,
                              logic [31:0] r_base);
    sent_start.push_back(r_start);
    sent_size.push_back(r_size);
    offer_item(OP_INSERT, r_start, r_size, r_base, $urandom, $urandom,
               1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic offer_classify(logic [31:0] src, logic [31:0] dst,
                                logic src_lin, logic dst_lin);
    offer_item(OP_CLASSIFY, $urandom, {1'($urandom_range(1)), 32'($urandom)}, $urandom,
               src, dst, src_lin, dst_lin);
  endtask

  task automatic idle_sender(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
    end
  endtask

  // sender stays idle until every result is back, bounded
  task automatic wait_for_results();
    int unsigned guard;
    guard = 0;
    do begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      guard++;
    end while (outstanding != 0 && guard < 100000);
  endtask

  // mostly back to back or short gaps, now and then a long one
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(4, 1);
    if (r < 96) return $urandom_range(40, 5);
    return $urandom_range(120, 41);
  endfunction

  // an address on or around the edges of a region already sent, or inside it
  function automatic logic [31:0] near_region();
    int unsigned k;
    longint unsigned s;
    longint unsigned z;
    if (sent_start.size() == 0) return $urandom;
    k = $urandom_range(sent_start.size() - 1);
    s = sent_start[k];
    z = sent_size[k];
    case ($urandom_range(5))
      0: return 32'(s);
      1: return 32'(s + z - 1);
      2: return 32'(s + z);
      3: return 32'(s - 1);
      default: return 32'(s + ($urandom % ((z == 0) ? 1 : z)));
    endcase
  endfunction

  task automatic offer_random_insert();
    longint unsigned st;
    longint unsigned sz;
    int unsigned r;
    int unsigned k;
    r  = $urandom_range(99);
    st = 64'($urandom);
    if (r < 60) sz = 64'($urandom_range(32'h1_0000, 1));
    else if (r < 80) sz = 64'($urandom_range(32'h1000_0000, 1));
    else if (r < 85) sz = 64'h1_0000_0000;
    else if (r < 88) sz = 0;
    else sz = 64'($urandom) + 1;
    // equal start or touching the end of an earlier region
    if ($urandom_range(9) == 0 && sent_start.size() != 0) begin
      k  = $urandom_range(sent_start.size() - 1);
      st = (sent_start[k] + ($urandom_range(1) ? 0 : sent_size[k])) & 64'hFFFF_FFFF;
    end
    // keep clear of the fill window
    if (st >= WIN_LO && st < WIN_HI) st = WIN_HI + (st - WIN_LO);
    else if (st < WIN_LO && st + sz > WIN_LO) sz = WIN_LO - st;
    offer_insert(32'(st), LEN_W'(sz), $urandom);
  endtask

  task automatic offer_random_classify();
    logic [31:0] src;
    logic [31:0] dst;
    src = ($urandom_range(9) < 7) ? near_region() : 32'($urandom);
    dst = ($urandom_range(9) < 7) ? near_region() : 32'($urandom);
    offer_classify(src, dst, $urandom_range(3) != 0, $urandom_range(3) != 0);
  endtask

  // receiver: random stalls, runs with none, and one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned run_left;
    int unsigned r;
    bit          hold_done;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    run_left      = 0;
    hold_done     = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold && !hold_done) begin
        m_axis_tready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (stall_left != 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (run_left != 0) begin
          run_left--;
        end else begin
          r = $urandom_range(99);
          if (r < 10) run_left = $urandom_range(200, 20);
          else if (r < 13) stall_left = $urandom_range(80, 20);
          else if (r < 40) stall_left = $urandom_range(3, 1);
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_INSERT;
    rx_hold       = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // empty table: nothing is memory
    offer_classify(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // zero length region, then a real one with the same start placed after it
    offer_insert(32'h1000_0000, 33'h0, 32'h1234_5678);
    offer_classify(32'h1000_0000, 32'h1000_0001, 1'b1, 1'b1);
    offer_insert(32'h1000_0000, 33'h1000, 32'hFFFF_F800);
    // overlaps the region just stored
    offer_insert(32'h1000_0800, 33'h10, 32'hA5A5_A5A5);
    // length past the top of the address space
    offer_insert(32'hFFFF_0000, 33'h1_0000_0000, 32'h0000_0000);
    offer_insert(32'h0000_0000, 33'h1, 32'hFFFF_FFFF);
    // fast path, source local address wraps
    offer_classify(32'h1000_0900, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // just past a region end / first byte of the lowest region
    offer_classify(32'h1000_1000, 32'h0000_0000, 1'b1, 1'b1);
    // inside but not linear
    offer_classify(32'h1000_0000, 32'h0000_0001, 1'b0, 1'b1);
    offer_classify(32'h1000_0FFF, 32'hFFFF_0000, 1'b1, 1'b0);
    // fills the gap exactly between two stored regions
    offer_insert(32'h0000_0001, 33'h0FFF_FFFF, $urandom);
    wait_for_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // long receiver hold-off while items keep coming
      if (i == 500) rx_hold = 1'b1;
      if (i == 900) wait_for_results();
      if (!(i >= 500 && i < 520) && (i / 100) % 3 != 1) idle_sender(gap_cycles());
      if ($urandom_range(99) < 25) offer_random_insert();
      else offer_random_classify();
    end

    // fill the reserved window: the table runs full on the way
    for (int k = 0; k < 17; k++) begin
      idle_sender(gap_cycles());
      offer_insert(32'(WIN_LO + k * 'h100), 33'h10, $urandom);
    end
    // collision on a full table reports collision, then a clean one reports full
    offer_insert(32'(WIN_LO + 'h8), 33'h10, $urandom);
    offer_insert(32'(WIN_LO + 'hF000), 33'h1, $urandom);
    offer_classify(32'(WIN_LO + 'h5), 32'(WIN_LO + 'h105), 1'b1, 1'b1);

    wait_for_results();
    repeat (100) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("dma_port_region_classifier_tb: PASS");
    end else begin
      $display("dma_port_region_classifier_tb: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #25_000_000;
    $display("dma_port_region_classifier_tb: FAIL");
    $finish;
  end

endmodule
